### src/tmc_pkg.sv
// tempo map converter package: field widths, opcodes, status codes and item types
// used by the interfaces and the top level; no dependencies
package tmc_pkg;

	localparam int OP_W    = 3;
	localparam int TICK_W  = 31;
	localparam int TEMPO_W = 18;
	localparam int BEAT_W  = 7;
	localparam int TIME_W  = 48;
	localparam int ST_W    = 2;

	// opcodes
	localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
	localparam logic [OP_W-1:0] OP_APPEND  = 3'd1;
	localparam logic [OP_W-1:0] OP_TICK2T  = 3'd2;
	localparam logic [OP_W-1:0] OP_T2TICK  = 3'd3;
	localparam logic [OP_W-1:0] OP_RESTART = 3'd4;

	// status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [ST_W-1:0] ST_SAT   = 2'd3;

	// fixed point: one tick of beat 1 is 2^19 / (5 * tempo) time units
	localparam int FRAC_SH   = 19;
	localparam int SCALE_W   = TEMPO_W + 3;           // 5 * tempo
	localparam int PROD_W    = 70;                    // 49 bit time delta times 21 bit scale
	localparam int DVD_W     = 57;                    // widest dividend of both paths
	localparam int MUL_STEPS = SCALE_W;
	localparam int DIV_STEPS = DVD_W;

	localparam logic [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
	localparam logic [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};
	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

	typedef struct packed {
		logic [OP_W-1:0]           opcode;
		logic [TICK_W-1:0]         seg_start_tick;
		logic [TEMPO_W-1:0]        seg_tempo;
		logic [BEAT_W-1:0]         seg_beat;
		logic [TICK_W-1:0]         query_tick;
		logic signed [TIME_W-1:0]  now_time;
	} req_item_t;

	typedef struct packed {
		logic signed [TIME_W-1:0]  time_result;
		logic [TICK_W-1:0]         tick_result;
		logic [ST_W-1:0]           status;
	} rsp_item_t;

	// one tempo map entry as stored in memory
	typedef struct packed {
		logic [TICK_W-1:0]         start_tick;
		logic [TEMPO_W-1:0]        tempo;
		logic [BEAT_W-1:0]         beat;
		logic signed [TIME_W-1:0]  start_time;
	} seg_entry_t;

endpackage

### src/tmc_if.sv
// valid/ready channel interfaces for request and response items
// depends on tmc_pkg
interface tmc_req_if;
	logic                 valid;
	logic                 ready;
	tmc_pkg::req_item_t   item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface tmc_rsp_if;
	logic                 valid;
	logic                 ready;
	tmc_pkg::rsp_item_t   item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

### src/tmc_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module tmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### src/tempo_map_tick_time_converter.sv
// tempo map tick/time converter top level: map memory, search, serial multiply and divide
// depends on tmc_pkg, tmc_if (tmc_req_if, tmc_rsp_if) and tmc_ram
//
//  channel | dir | handshake       | item
//  req     | in  | valid/ready     | opcode, segment fields, query tick, now time
//  rsp     | out | valid/ready     | time_result, tick_result, status
//  cfg     | in  | cfg_we          | time_offset (48 bit signed)
//
// clear, restart, unused opcodes, rejected appends, the first append and queries on an
// empty map go straight to the result. queries read the map one entry a cycle, then run
// a shift-add multiplier over the 21 bit scale and a restoring divider over the 57 bit
// dividend; a later append reads the previous segment, then multiplies and divides.
// a time query with no segment begun ends after the scan. one item is worked at a time;
// the last cycle waits while an earlier result still sits unaccepted on rsp.
// reset clears the map count, held tick and offset; map contents are only read below
// the count, so they need no clearing.
module tempo_map_tick_time_converter #(
	parameter int MAX_SEGMENTS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic signed [tmc_pkg::TIME_W-1:0]   cfg_data,
	tmc_req_if.sink                             req,
	tmc_rsp_if.source                           rsp
);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int EW = $bits(tmc_pkg::seg_entry_t);
	localparam int TW = tmc_pkg::TIME_W + 1;    // offset-corrected time
	localparam int SW = tmc_pkg::TIME_W + 10;   // start time plus increment
	localparam int NW = $clog2(tmc_pkg::DIV_STEPS);

	typedef enum logic [3:0] {
		S_IDLE, S_RDPREV, S_SCAN, S_PREP, S_MUL, S_DLOAD, S_DIV, S_FIN, S_DONE
	} state_t;

	state_t                              state_q;
	logic [tmc_pkg::OP_W-1:0]            op_q;
	logic [tmc_pkg::TICK_W-1:0]          tgt_tick_q;
	logic [tmc_pkg::TICK_W-1:0]          stick_q;
	logic [tmc_pkg::TEMPO_W-1:0]         tempo_q;
	logic [tmc_pkg::BEAT_W-1:0]          beat_q;
	logic signed [TW-1:0]                t_q;
	logic signed [tmc_pkg::TIME_W-1:0]   offset_q;
	logic [CW-1:0]                       total_q;
	logic [tmc_pkg::TICK_W-1:0]          held_q;
	logic [tmc_pkg::TICK_W-1:0]          k_tick_q;
	logic [tmc_pkg::TEMPO_W-1:0]         k_tempo_q;
	logic [tmc_pkg::BEAT_W-1:0]          k_beat_q;
	logic signed [tmc_pkg::TIME_W-1:0]   k_time_q;
	logic                                found_q;
	logic [CW-1:0]                       iss_q;
	logic                                chk_vld_s1;
	logic [IW-1:0]                       chk_idx_s1;
	logic                                neg_q;
	logic [tmc_pkg::PROD_W-1:0]          mc_q;
	logic [tmc_pkg::SCALE_W-1:0]         mp_q;
	logic [tmc_pkg::PROD_W-1:0]          acc_q;
	logic [NW-1:0]                       cnt_q;
	logic [tmc_pkg::DVD_W-1:0]           quo_q;
	logic [tmc_pkg::SCALE_W-1:0]         rem_q;
	logic [tmc_pkg::SCALE_W-1:0]         den_q;
	logic signed [tmc_pkg::TIME_W-1:0]   res_time_q;
	logic [tmc_pkg::ST_W-1:0]            res_st_q;
	logic                                rsp_vld_q;
	tmc_pkg::rsp_item_t                  rsp_q;

	logic                                accept;
	logic [CW-1:0]                       tot_m1;
	logic                                map_full;
	logic                                seg_bad;
	logic [tmc_pkg::ST_W-1:0]            acc_st;
	state_t                              acc_state;
	logic                                ram_we;
	logic [IW-1:0]                       ram_waddr;
	tmc_pkg::seg_entry_t                 wr_ent;
	logic [IW-1:0]                       ram_raddr;
	logic [EW-1:0]                       ram_rdata;
	tmc_pkg::seg_entry_t                 rd_ent;
	logic                                chk_last;
	logic                                cap;
	logic                                stop;
	logic signed [TW-1:0]                t_in;
	logic [31:0]                         dtick;
	logic [31:0]                         dmag;
	logic [TW:0]                         dt;
	logic [tmc_pkg::SCALE_W-1:0]         k_scale;
	logic [tmc_pkg::SCALE_W-1:0]         k_beat_ext;
	logic [tmc_pkg::PROD_W-1:0]          acc_nx;
	logic [tmc_pkg::SCALE_W:0]           rem_sh;
	logic                                div_ge;
	logic [tmc_pkg::SCALE_W:0]           rem_sub;
	logic [SW-1:0]                       inc;
	logic [SW-1:0]                       sum;
	logic                                tsat_hi;
	logic                                tsat_lo;
	logic [tmc_pkg::TIME_W-1:0]          fin_time;
	logic [31:0]                         tick_sum;
	logic                                tick_sat;
	logic                                rsp_free;

	// tempo map memory
	tmc_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_SEGMENTS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (EW'(wr_ent)),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);
	assign rd_ent = tmc_pkg::seg_entry_t'(ram_rdata);

	// handshake and map status
	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign tot_m1   = total_q - CW'(1);
	assign map_full = (total_q == CW'(MAX_SEGMENTS));
	assign seg_bad  = (req.item.seg_tempo == '0) || (req.item.seg_beat == '0);
	assign rsp_free = !rsp_vld_q || rsp.ready;
	assign rsp.valid = rsp_vld_q;
	assign rsp.item  = rsp_q;

	// status and next state of an accepted item
	always_comb begin
		acc_st    = tmc_pkg::ST_OK;
		acc_state = S_DONE;
		unique case (req.item.opcode) inside
			tmc_pkg::OP_APPEND: begin
				if (map_full) begin
					acc_st = tmc_pkg::ST_FULL;
				end else if (seg_bad) begin
					acc_st = tmc_pkg::ST_EMPTY;
				end else if (total_q != '0) begin
					acc_state = S_RDPREV;
				end
			end
			tmc_pkg::OP_TICK2T, tmc_pkg::OP_T2TICK: begin
				if (total_q == '0) begin
					acc_st = tmc_pkg::ST_EMPTY;
				end else begin
					acc_state = S_SCAN;
				end
			end
			default: begin
			end
		endcase
	end

	// read address: scan pointer or previous segment for an append
	assign ram_raddr = (state_q == S_SCAN) ? iss_q[IW-1:0] : tot_m1[IW-1:0];

	// offset-corrected time of the incoming item
	assign t_in = TW'(req.item.now_time) - TW'(offset_q);

	// write port: first segment at once, later segments after the start time is known
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = total_q[IW-1:0];
		wr_ent    = '{start_tick: stick_q, tempo: tempo_q, beat: beat_q,
			start_time: fin_time};
		if (state_q == S_IDLE) begin
			ram_we = accept && (req.item.opcode == tmc_pkg::OP_APPEND) && !map_full &&
				!seg_bad && (total_q == '0);
			wr_ent = '{start_tick: req.item.seg_start_tick, tempo: req.item.seg_tempo,
				beat: req.item.seg_beat, start_time: '0};
		end else if (state_q == S_FIN) begin
			ram_we = (op_q == tmc_pkg::OP_APPEND);
		end
	end

	// segment search on the entry read back this cycle
	assign chk_last = (chk_idx_s1 == tot_m1[IW-1:0]);
	always_comb begin
		if (op_q == tmc_pkg::OP_TICK2T) begin
			cap  = (chk_idx_s1 == '0) || (rd_ent.start_tick <= tgt_tick_q);
			stop = (rd_ent.start_tick > tgt_tick_q) || chk_last;
		end else begin
			cap  = (TW'(rd_ent.start_time) <= t_q);
			stop = chk_last;
		end
	end

	// operands of both paths
	assign dtick      = {1'b0, tgt_tick_q} - {1'b0, k_tick_q};
	assign dmag       = dtick[31] ? (~dtick + 32'd1) : dtick;
	assign dt         = (TW+1)'(t_q) - (TW+1)'(k_time_q);
	assign k_scale    = {1'b0, k_tempo_q, 2'b00} + {3'b000, k_tempo_q};
	assign k_beat_ext = {{(tmc_pkg::SCALE_W-tmc_pkg::BEAT_W){1'b0}}, k_beat_q};

	// multiplier step and divider step
	assign acc_nx  = acc_q + (mp_q[0] ? mc_q : '0);
	assign rem_sh  = {rem_q, quo_q[tmc_pkg::DVD_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign div_ge  = (rem_sh >= {1'b0, den_q});

	// time path result with saturation
	assign inc      = neg_q ? (~{1'b0, quo_q} + SW'(1)) : {1'b0, quo_q};
	assign sum      = SW'(k_time_q) + inc;
	assign tsat_hi  = !sum[SW-1] && (sum[SW-2:tmc_pkg::TIME_W-1] != '0);
	assign tsat_lo  = sum[SW-1] && (sum[SW-2:tmc_pkg::TIME_W-1] != '1);
	assign fin_time = tsat_hi ? tmc_pkg::TIME_MAX :
		(tsat_lo ? tmc_pkg::TIME_MIN : sum[tmc_pkg::TIME_W-1:0]);

	// tick path result with saturation
	assign tick_sum = {1'b0, k_tick_q} + {1'b0, quo_q[tmc_pkg::TICK_W-1:0]};
	assign tick_sat = (|quo_q[tmc_pkg::DVD_W-1:tmc_pkg::TICK_W]) || tick_sum[31];

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			total_q    <= '0;
			held_q     <= '0;
			offset_q   <= '0;
			rsp_vld_q  <= 1'b0;
			chk_vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				offset_q <= cfg_data;
			end
			// result register
			if ((state_q == S_DONE) && rsp_free) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q       <= req.item.opcode;
						stick_q    <= req.item.seg_start_tick;
						tempo_q    <= req.item.seg_tempo;
						beat_q     <= req.item.seg_beat;
						t_q        <= t_in;
						tgt_tick_q <= (req.item.opcode == tmc_pkg::OP_APPEND) ?
							req.item.seg_start_tick : req.item.query_tick;
						res_time_q <= '0;
						res_st_q   <= acc_st;
						iss_q      <= '0;
						found_q    <= 1'b0;
						chk_vld_s1 <= 1'b0;
						state_q    <= acc_state;
						// map count: clear, or the first segment written at once
						if (req.item.opcode == tmc_pkg::OP_CLEAR) begin
							total_q <= '0;
						end else if (ram_we) begin
							total_q <= CW'(1);
						end
						if (req.item.opcode == tmc_pkg::OP_RESTART) begin
							held_q <= '0;
						end
					end
				end
				S_RDPREV: begin
					k_tick_q  <= rd_ent.start_tick;
					k_tempo_q <= rd_ent.tempo;
					k_beat_q  <= rd_ent.beat;
					k_time_q  <= rd_ent.start_time;
					state_q   <= S_PREP;
				end
				S_SCAN: begin
					// issue one read a cycle, check the one returned
					if (iss_q < total_q) begin
						iss_q <= iss_q + CW'(1);
					end
					chk_vld_s1 <= (iss_q < total_q) && !(chk_vld_s1 && stop);
					chk_idx_s1 <= iss_q[IW-1:0];
					if (chk_vld_s1) begin
						if (cap) begin
							k_tick_q  <= rd_ent.start_tick;
							k_tempo_q <= rd_ent.tempo;
							k_beat_q  <= rd_ent.beat;
							k_time_q  <= rd_ent.start_time;
							found_q   <= 1'b1;
						end
						if (stop) begin
							state_q <= (cap || found_q) ? S_PREP : S_DONE;
						end
					end
				end
				S_PREP: begin
					acc_q <= '0;
					cnt_q <= '0;
					if (op_q == tmc_pkg::OP_T2TICK) begin
						mc_q  <= tmc_pkg::PROD_W'(dt[TW-1:0]);
						mp_q  <= k_scale;
						den_q <= k_beat_ext;
					end else begin
						neg_q <= dtick[31];
						mc_q  <= tmc_pkg::PROD_W'(dmag);
						mp_q  <= k_beat_ext;
						den_q <= k_scale;
					end
					state_q <= S_MUL;
				end
				S_MUL: begin
					acc_q <= acc_nx;
					mc_q  <= {mc_q[tmc_pkg::PROD_W-2:0], 1'b0};
					mp_q  <= {1'b0, mp_q[tmc_pkg::SCALE_W-1:1]};
					cnt_q <= cnt_q + NW'(1);
					if (cnt_q == NW'(tmc_pkg::MUL_STEPS - 1)) begin
						state_q <= S_DLOAD;
					end
				end
				S_DLOAD: begin
					rem_q <= '0;
					cnt_q <= '0;
					if (op_q == tmc_pkg::OP_T2TICK) begin
						quo_q <= tmc_pkg::DVD_W'(acc_q[tmc_pkg::PROD_W-1:tmc_pkg::FRAC_SH]);
					end else begin
						quo_q <= {acc_q[tmc_pkg::DVD_W-tmc_pkg::FRAC_SH-1:0],
							{tmc_pkg::FRAC_SH{1'b0}}};
					end
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= div_ge ? rem_sub[tmc_pkg::SCALE_W-1:0] :
						rem_sh[tmc_pkg::SCALE_W-1:0];
					quo_q <= {quo_q[tmc_pkg::DVD_W-2:0], div_ge};
					cnt_q <= cnt_q + NW'(1);
					if (cnt_q == NW'(tmc_pkg::DIV_STEPS - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (op_q == tmc_pkg::OP_T2TICK) begin
						held_q   <= tick_sat ? tmc_pkg::TICK_MAX : tick_sum[tmc_pkg::TICK_W-1:0];
						res_st_q <= tick_sat ? tmc_pkg::ST_SAT : tmc_pkg::ST_OK;
					end else begin
						res_st_q <= (tsat_hi || tsat_lo) ? tmc_pkg::ST_SAT : tmc_pkg::ST_OK;
						if (op_q == tmc_pkg::OP_APPEND) begin
							total_q <= total_q + CW'(1);
						end else begin
							res_time_q <= fin_time;
						end
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_q   <= '{time_result: res_time_q, tick_result: held_q,
							status: res_st_q};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// map count stays within the memory
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(MAX_SEGMENTS))
		else $error("tempo map count beyond capacity");

	// divider never runs on a zero divisor
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (den_q != '0))
		else $error("divide by zero in converter");

	// a nonzero time only comes with ok or saturated status
	a_time_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_vld_q && (rsp_q.time_result != '0)) |->
		((rsp_q.status == tmc_pkg::ST_OK) || (rsp_q.status == tmc_pkg::ST_SAT)))
		else $error("time result with error status");

	// a result is never dropped while it waits
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_vld_q && !rsp.ready) |=> rsp_vld_q)
		else $error("pending result lost");

endmodule

### tb/tempo_map_tick_time_converter_test.sv
// testbench for the tempo map tick/time converter: directed and random items on req,
// results on rsp checked against an in-bench model of the tempo map
// depends on tmc_pkg, tmc_if and the tempo_map_tick_time_converter top level
module tempo_map_tick_time_converter_test;

	localparam int SEGS      = 16;
	localparam int CYCLE_CAP = 3000000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic signed [tmc_pkg::TIME_W-1:0] cfg_data;

	tmc_req_if req_ch ();
	tmc_rsp_if rsp_ch ();

	tempo_map_tick_time_converter #(.MAX_SEGMENTS(SEGS)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req      (req_ch.sink),
		.rsp      (rsp_ch.source)
	);

	// model of the tempo map
	int unsigned map_tick [SEGS];
	int unsigned map_tempo [SEGS];
	int unsigned map_beat [SEGS];
	longint      map_time [SEGS];
	int          map_count;
	bit [tmc_pkg::TICK_W-1:0] held_count;
	longint      offset_val;

	tmc_pkg::rsp_item_t pending_results[$];
	int  fail_count = 0;
	int  send_idle_pct;
	int  recv_idle_pct;
	longint cycle_count = 0;

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// time reached from map entry k after a signed tick delta
	function automatic longint time_at(int k, longint dtick, inout bit sat);
		longint num;
		longint inc;
		longint sum;
		num = dtick * longint'(map_beat[k]) * (longint'(1) << tmc_pkg::FRAC_SH);
		inc = num / (longint'(5) * longint'(map_tempo[k]));
		sum = map_time[k] + inc;
		if (sum > longint'(tmc_pkg::TIME_MAX)) begin
			sat = 1'b1;
			sum = longint'(tmc_pkg::TIME_MAX);
		end else if (sum < -(longint'(1) << (tmc_pkg::TIME_W-1))) begin
			sat = 1'b1;
			sum = -(longint'(1) << (tmc_pkg::TIME_W-1));
		end
		return sum;
	endfunction

	// apply one accepted item to the map model, return the result it causes
	function automatic tmc_pkg::rsp_item_t tempo_map_apply(tmc_pkg::req_item_t r);
		tmc_pkg::rsp_item_t o;
		longint tres;
		bit sat;
		bit found;
		int k;
		longint t;
		logic [127:0] q;
		logic [127:0] v;
		tres = 0;
		sat = 1'b0;
		found = 1'b0;
		k = 0;
		o.status = tmc_pkg::ST_OK;
		case (r.opcode)
			tmc_pkg::OP_CLEAR: begin
				map_count = 0;
			end
			tmc_pkg::OP_APPEND: begin
				if (map_count >= SEGS) begin
					o.status = tmc_pkg::ST_FULL;
				end else if (r.seg_tempo == 0 || r.seg_beat == 0) begin
					o.status = tmc_pkg::ST_EMPTY;
				end else begin
					t = 0;
					if (map_count > 0)
						t = time_at(map_count - 1, longint'(r.seg_start_tick)
							- longint'(map_tick[map_count-1]), sat);
					map_tick[map_count] = 32'(r.seg_start_tick);
					map_tempo[map_count] = 32'(r.seg_tempo);
					map_beat[map_count] = 32'(r.seg_beat);
					map_time[map_count] = t;
					map_count++;
					if (sat) o.status = tmc_pkg::ST_SAT;
				end
			end
			tmc_pkg::OP_TICK2T: begin
				if (map_count == 0) begin
					o.status = tmc_pkg::ST_EMPTY;
				end else begin
					// first start tick above the query ends the search
					for (int i = 0; i < map_count; i++) begin
						if (map_tick[i] <= 32'(r.query_tick)) k = i;
						else break;
					end
					tres = time_at(k, longint'(r.query_tick) - longint'(map_tick[k]), sat);
					if (sat) o.status = tmc_pkg::ST_SAT;
				end
			end
			tmc_pkg::OP_T2TICK: begin
				if (map_count == 0) begin
					o.status = tmc_pkg::ST_EMPTY;
				end else begin
					t = longint'(r.now_time) - offset_val;
					for (int i = 0; i < map_count; i++) begin
						if (map_time[i] <= t) begin
							k = i;
							found = 1'b1;
						end
					end
					if (found) begin
						q = (128'(t - map_time[k]) * 128'(5 * map_tempo[k]))
							/ (128'(map_beat[k]) << tmc_pkg::FRAC_SH);
						v = q + 128'(map_tick[k]);
						if (q > 128'(tmc_pkg::TICK_MAX) || v > 128'(tmc_pkg::TICK_MAX)) begin
							v = 128'(tmc_pkg::TICK_MAX);
							o.status = tmc_pkg::ST_SAT;
						end
						held_count = v[tmc_pkg::TICK_W-1:0];
					end
				end
			end
			tmc_pkg::OP_RESTART: begin
				held_count = '0;
			end
			default: ;
		endcase
		o.time_result = tres[tmc_pkg::TIME_W-1:0];
		o.tick_result = held_count;
		return o;
	endfunction

	// receiver stalls
	always @(posedge clk) begin
		rsp_ch.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result item with nothing expected");
				fail_count++;
			end else begin
				tmc_pkg::rsp_item_t e;
				e = pending_results.pop_front();
				if (rsp_ch.item.time_result !== e.time_result) begin
					$error("time_result expected %0d got %0d", e.time_result,
						rsp_ch.item.time_result);
					fail_count++;
				end
				if (rsp_ch.item.tick_result !== e.tick_result) begin
					$error("tick_result expected %0d got %0d", e.tick_result,
						rsp_ch.item.tick_result);
					fail_count++;
				end
				if (rsp_ch.item.status !== e.status) begin
					$error("status expected %0d got %0d", e.status, rsp_ch.item.status);
					fail_count++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// send one item, with a random gap before it
	task automatic send_item(tmc_pkg::req_item_t it);
		tmc_pkg::rsp_item_t exp_item;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_ch.valid <= 1'b1;
		req_ch.item <= it;
		do @(posedge clk); while (!req_ch.ready);
		exp_item = tempo_map_apply(it);
		pending_results.insert(pending_results.size(), exp_item);
	endtask

	// fully random item, every field over its whole width
	function automatic tmc_pkg::req_item_t any_item();
		tmc_pkg::req_item_t it;
		it.opcode = tmc_pkg::OP_W'($urandom_range(7));
		it.seg_start_tick = tmc_pkg::TICK_W'($urandom);
		it.seg_tempo = tmc_pkg::TEMPO_W'($urandom);
		it.seg_beat = tmc_pkg::BEAT_W'($urandom);
		it.query_tick = tmc_pkg::TICK_W'($urandom);
		it.now_time = tmc_pkg::TIME_W'({$urandom, $urandom});
		return it;
	endfunction

	function automatic tmc_pkg::req_item_t op_item(logic [tmc_pkg::OP_W-1:0] op);
		tmc_pkg::req_item_t it;
		it = any_item();
		it.opcode = op;
		return it;
	endfunction

	function automatic tmc_pkg::req_item_t seg_item(int unsigned st, int unsigned tempo,
			int unsigned beat);
		tmc_pkg::req_item_t it;
		it = op_item(tmc_pkg::OP_APPEND);
		it.seg_start_tick = tmc_pkg::TICK_W'(st);
		it.seg_tempo = tmc_pkg::TEMPO_W'(tempo);
		it.seg_beat = tmc_pkg::BEAT_W'(beat);
		return it;
	endfunction

	function automatic tmc_pkg::req_item_t tick_query(int unsigned qt);
		tmc_pkg::req_item_t it;
		it = op_item(tmc_pkg::OP_TICK2T);
		it.query_tick = tmc_pkg::TICK_W'(qt);
		return it;
	endfunction

	function automatic tmc_pkg::req_item_t time_query(longint now);
		tmc_pkg::req_item_t it;
		it = op_item(tmc_pkg::OP_T2TICK);
		it.now_time = now[tmc_pkg::TIME_W-1:0];
		return it;
	endfunction

	// wait until every result is in and the block has settled
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_offset(longint v);
		cfg_we <= 1'b1;
		cfg_data <= v[tmc_pkg::TIME_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		offset_val = longint'($signed(v[tmc_pkg::TIME_W-1:0]));
		@(posedge clk);
	endtask

	// empty map, rejected appends, unused opcodes, map edge cases
	task automatic test_basic_ops();
		send_item(op_item(tmc_pkg::OP_CLEAR));
		send_item(op_item(tmc_pkg::OP_TICK2T));
		send_item(op_item(tmc_pkg::OP_T2TICK));
		send_item(seg_item(1000, 0, 4));
		send_item(seg_item(1000, 120 << 8, 0));
		send_item(seg_item(1000, 120 << 8, 4));
		send_item(time_query(-5));
		send_item(tick_query(0));
		send_item(seg_item(5000, 262143, 127));
		send_item(seg_item(3000, 1, 1));
		send_item(tick_query(32'h7fffffff));
		send_item(tick_query(4000));
		send_item(time_query(longint'(tmc_pkg::TIME_MAX)));
		send_item(time_query(12345678));
		send_item(op_item(tmc_pkg::OP_RESTART));
		send_item(op_item(3'd5));
		send_item(op_item(3'd6));
		send_item(op_item(3'd7));
		drain();
	endtask

	// fill the map and append past its end
	task automatic test_map_full();
		send_item(op_item(tmc_pkg::OP_CLEAR));
		for (int i = 0; i < SEGS; i++)
			send_item(seg_item(i * 9600, (60 + 10 * i) << 8, 1 << (i % 7)));
		send_item(seg_item(500000, 100 << 8, 4));
		send_item(tick_query(100000));
		send_item(time_query(map_time[SEGS-1] + 1000));
		drain();
	endtask

	// offset at both extremes
	task automatic test_offset_extremes();
		write_offset(longint'(tmc_pkg::TIME_MAX));
		send_item(time_query(0));
		send_item(time_query(longint'(tmc_pkg::TIME_MAX)));
		drain();
		write_offset(-(longint'(1) << (tmc_pkg::TIME_W-1)));
		send_item(time_query(0));
		send_item(time_query(-(longint'(1) << (tmc_pkg::TIME_W-1))));
		drain();
		write_offset(0);
	endtask

	// random tempo maps followed by queries, with some noise
	task automatic test_random_maps(int n_items);
		int sent;
		int n;
		int unsigned st;
		int k;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				send_item(any_item());
				sent++;
				continue;
			end
			if ($urandom_range(4) != 0) begin
				send_item(op_item(tmc_pkg::OP_CLEAR));
				sent++;
			end
			n = ($urandom_range(7) == 0) ? int'($urandom_range(17)) :
				int'($urandom_range(1, 5));
			st = $urandom_range(3) == 0 ? $urandom : $urandom_range(20000);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(5) == 0)
					send_item(seg_item($urandom, $urandom_range(3) == 0 ? $urandom_range(3) :
						$urandom, $urandom_range(127)));
				else
					send_item(seg_item(st, $urandom_range(40 << 8, 300 << 8),
						1 << $urandom_range(6)));
				sent++;
				st += $urandom_range(50000);
				st &= 32'h7fffffff;
			end
			n = int'($urandom_range(1, 8));
			for (int i = 0; i < n; i++) begin
				k = (map_count > 0) ? int'($urandom_range(map_count - 1)) : 0;
				case ($urandom_range(4))
					0: send_item(tick_query($urandom));
					1: send_item(tick_query(map_tick[k] + $urandom_range(100000)));
					2: send_item(time_query(map_time[k] + offset_val
						+ longint'($urandom_range(1 << 22)) - 1000));
					3: send_item(time_query({$urandom, $urandom}));
					default: send_item(op_item(tmc_pkg::OP_RESTART));
				endcase
				sent++;
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.item = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		map_count = 0;
		held_count = '0;
		offset_val = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_map_full();
		test_offset_extremes();

		send_idle_pct = 22;
		recv_idle_pct = 64;
		write_offset(longint'($urandom_range(1 << 20)));
		test_random_maps(580);

		send_idle_pct = 64;
		recv_idle_pct = 22;
		write_offset(-longint'($urandom));
		test_random_maps(580);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_offset(0);
		test_random_maps(580);

		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### tempo_map_tick_time_converter.f
src/tmc_pkg.sv
src/tmc_if.sv
src/tmc_ram.sv
src/tempo_map_tick_time_converter.sv
tb/tempo_map_tick_time_converter_test.sv
